### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

### sv/mrbf_pkg.sv
`timescale 1ns / 1ps
package mrbf_pkg;

	localparam int W         = 64;
	localparam int DIV_BITS  = W;
	localparam int LANE_LAT  = 2 * DIV_BITS + 4;
	localparam int N_RES     = 4;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_COMPUTE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEMORY    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STORAGE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH = 8'd3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} st_t;

	typedef struct packed {
		logic [W-1:0] price;
		logic [W-1:0] target;
		logic [W-1:0] span;
		logic [W-1:0] hi;
		logic         up;
		logic         eq;
		logic         inv;
		logic         ovf;
	} ctx_t;

	typedef struct packed {
		ctx_t         ctx;
		logic [W-1:0] num;
		logic [W-1:0] rem;
		logic [W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [W-1:0] p0;
		logic [W-1:0] p1;
		logic [W-1:0] p2;
		logic         hh;
	} pp_t;

	typedef struct packed {
		logic [W-1:0] prod;
		logic         ovf;
	} mres_t;

	// one restoring division step
	function automatic div_t div_step(div_t a);
		div_t        b;
		logic [W:0]   r;
		logic [W+1:0] d;
		b = a;
		r = {a.rem, a.num[W-1]};
		d = {1'b0, r} - {2'b00, a.ctx.target};
		b.num = {a.num[W-2:0], 1'b0};
		if (!d[W+1]) begin
			b.rem = d[W-1:0];
			b.quo = {a.quo[W-2:0], 1'b1};
		end else begin
			b.rem = r[W-1:0];
			b.quo = {a.quo[W-2:0], 1'b0};
		end
		return b;
	endfunction

	function automatic pp_t mul_pp(logic [W-1:0] a, logic [W-1:0] b);
		pp_t p;
		p.p0 = W'(a[W/2-1:0]) * W'(b[W/2-1:0]);
		p.p1 = W'(a[W-1:W/2]) * W'(b[W/2-1:0]);
		p.p2 = W'(a[W/2-1:0]) * W'(b[W-1:W/2]);
		p.hh = (a[W-1:W/2] != '0) && (b[W-1:W/2] != '0);
		return p;
	endfunction

	function automatic mres_t mul_join(pp_t p);
		mres_t       m;
		logic [W/2:0]   mid;
		logic [W/2+1:0] hs;
		mid = {1'b0, p.p1[W/2-1:0]} + {1'b0, p.p2[W/2-1:0]};
		hs  = {2'b00, p.p0[W-1:W/2]} + {1'b0, mid};
		m.ovf  = p.hh || (p.p1[W-1:W/2] != '0) || (p.p2[W-1:W/2] != '0)
			|| (hs[W/2+1:W/2] != '0);
		m.prod = {hs[W/2-1:0], p.p0[W/2-1:0]};
		return m;
	endfunction

endpackage

### sv/mrbf_div.sv
`timescale 1ns / 1ps
module mrbf_div import mrbf_pkg::*; (
	input  logic clk,
	input  logic en,
	input  div_t din,
	output div_t dout
);

	div_t stg_s [DIV_BITS+1];

	assign stg_s[0] = din;

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k+1] <= div_step(stg_s[k]);
			end
		end
	end

	assign dout = stg_s[DIV_BITS];

endmodule

### sv/mrbf_lane.sv
`timescale 1ns / 1ps
module mrbf_lane import mrbf_pkg::*; (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] price,
	input  logic [W-1:0] used,
	input  logic [W-1:0] target,
	output logic [W-1:0] res,
	output st_t          st
);

	ctx_t         ctx_s1, ctx_s2, ctx_s3;
	pp_t          ppq_s2, ppr_s2;
	logic [W-1:0] lo_s3;
	logic [W-1:0] res_s4;
	st_t          st_s4;
	div_t         d1_in, d1_out, d2_in, d2_out;
	ctx_t         c0, c3;
	mres_t        mq, mr;
	logic [W:0]   sum;
	logic [W-1:0] delta;
	logic [W-1:0] step;
	logic [W:0]   rise;
	logic [W-1:0] nres;
	logic         novf;

	always_comb begin
		c0.price  = (price == '0) ? W'(1) : price;
		c0.target = target;
		c0.up     = used > target;
		c0.eq     = used == target;
		c0.span   = c0.up ? used - target : target - used;
		c0.inv    = target == '0;
		c0.hi     = '0;
		c0.ovf    = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= c0;
		end
	end

	assign d1_in = '{ctx: ctx_s1, num: ctx_s1.price, rem: '0, quo: '0};

	mrbf_div u_div1 (.clk(clk), .en(en), .din(d1_in), .dout(d1_out));

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= d1_out.ctx;
			ppq_s2 <= mul_pp(d1_out.quo, d1_out.ctx.span);
			ppr_s2 <= mul_pp(d1_out.rem, d1_out.ctx.span);
		end
	end

	always_comb begin
		mq = mul_join(ppq_s2);
		mr = mul_join(ppr_s2);
		c3 = ctx_s2;
		c3.hi  = mq.prod;
		c3.ovf = mq.ovf || mr.ovf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= c3;
			lo_s3  <= mr.prod;
		end
	end

	assign d2_in = '{ctx: ctx_s3, num: lo_s3, rem: '0, quo: '0};

	mrbf_div u_div2 (.clk(clk), .en(en), .din(d2_in), .dout(d2_out));

	always_comb begin
		sum   = {1'b0, d2_out.ctx.hi} + {1'b0, d2_out.quo};
		delta = {3'b000, sum[W-1:3]};
		step  = (delta == '0) ? W'(1) : delta;
		rise  = {1'b0, d2_out.ctx.price} + {1'b0, step};
		novf  = d2_out.ctx.ovf || sum[W];
		nres  = '0;
		if (d2_out.ctx.eq) begin
			nres = d2_out.ctx.price;
			novf = 1'b0;
		end else if (d2_out.ctx.up) begin
			nres = rise[W-1:0];
			novf = novf || rise[W];
		end else begin
			nres = (delta >= d2_out.ctx.price) ? W'(1) : d2_out.ctx.price - delta;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= nres;
			if (d2_out.ctx.inv) begin
				st_s4 <= ST_INVALID;
			end else if (novf) begin
				st_s4 <= ST_OVERFLOW;
			end else begin
				st_s4 <= ST_OK;
			end
		end
	end

	assign res = res_s4;
	assign st  = st_s4;

endmodule

### sv/multi_resource_base_fee_update.sv
`timescale 1ns / 1ps
// Four-resource base price update. An item of four prices and four usages
// passes one capture stage, two 64-stage bit-per-stage restoring dividers,
// two multiply stages, one final adjust stage per resource lane, and the
// output register. Throughput is one item per cycle whenever out_stall is
// low; out_stall with out_valid high halts the whole pipeline. Targets are
// written through the cfg port (index 0..3, others ignored), reset to one,
// and must only change while the pipeline is empty.
module multi_resource_base_fee_update import mrbf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]         cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [W-1:0]         price_compute,
	input  logic [W-1:0]         price_memory,
	input  logic [W-1:0]         price_storage,
	input  logic [W-1:0]         price_bandwidth,
	input  logic [W-1:0]         used_compute,
	input  logic [W-1:0]         used_memory,
	input  logic [W-1:0]         used_storage,
	input  logic [W-1:0]         used_bandwidth,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [W-1:0]         new_price_compute,
	output logic [W-1:0]         new_price_memory,
	output logic [W-1:0]         new_price_storage,
	output logic [W-1:0]         new_price_bandwidth,
	output logic [1:0]           status
);

`include "assert_macros.svh"

	logic [W-1:0] target_q [N_RES];
	logic [W-1:0] price_a  [N_RES];
	logic [W-1:0] used_a   [N_RES];
	logic [W-1:0] res_a    [N_RES];
	st_t          st_a     [N_RES];
	logic [LANE_LAT-1:0] vld_s;
	logic         out_valid_q;
	logic [W-1:0] price_q  [N_RES];
	st_t          status_q;
	st_t          sel;
	logic         found;
	logic         en;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_RES; i++) begin
				target_q[i] <= W'(1);
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COMPUTE:   target_q[0] <= cfg_data;
				REG_MEMORY:    target_q[1] <= cfg_data;
				REG_STORAGE:   target_q[2] <= cfg_data;
				REG_BANDWIDTH: target_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign price_a[0] = price_compute;
	assign price_a[1] = price_memory;
	assign price_a[2] = price_storage;
	assign price_a[3] = price_bandwidth;
	assign used_a[0]  = used_compute;
	assign used_a[1]  = used_memory;
	assign used_a[2]  = used_storage;
	assign used_a[3]  = used_bandwidth;

	for (genvar r = 0; r < N_RES; r++) begin : g_lane
		mrbf_lane u_lane (
			.clk    (clk),
			.en     (en),
			.price  (price_a[r]),
			.used   (used_a[r]),
			.target (target_q[r]),
			.res    (res_a[r]),
			.st     (st_a[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[LANE_LAT-2:0], in_valid};
			out_valid_q <= vld_s[LANE_LAT-1];
		end
	end

	// first failing resource decides
	always_comb begin
		sel   = ST_OK;
		found = 1'b0;
		for (int i = 0; i < N_RES; i++) begin
			if (!found && st_a[i] != ST_OK) begin
				sel   = st_a[i];
				found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= sel;
			for (int i = 0; i < N_RES; i++) begin
				price_q[i] <= found ? '0 : res_a[i];
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign new_price_compute   = price_q[0];
	assign new_price_memory    = price_q[1];
	assign new_price_storage   = price_q[2];
	assign new_price_bandwidth = price_q[3];
	assign status              = status_q;

	`ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status != ST_OK,
		new_price_compute == '0 && new_price_memory == '0 && new_price_storage == '0 && new_price_bandwidth == '0)
	`ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	`ASSERT_NXT(a_vld_hold, clk, arst_n, in_stall, $stable(vld_s))

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import mrbf_pkg::*;

	typedef struct {
		logic [W-1:0] p [N_RES];
		logic [1:0]   st;
	} fee_res_t;

	class fee_board;
		logic [W-1:0] targets [N_RES];
		fee_res_t     pending [$];
		int           errors;

		function new();
			foreach (targets[i]) targets[i] = 1;
			errors = 0;
		endfunction

		function automatic st_t lane_price(logic [W-1:0] price, logic [W-1:0] used,
				logic [W-1:0] tgt, output logic [W-1:0] res);
			logic [W-1:0] span, q, rem, lo, delta;
			logic [2*W-1:0] hi_w, lo_w;
			logic [W:0] sum;
			res = '0;
			if (tgt == 0) return ST_INVALID;
			if (price == 0) price = 1;
			if (used == tgt) begin
				res = price;
				return ST_OK;
			end
			span = (used > tgt) ? used - tgt : tgt - used;
			q = price / tgt;
			rem = price % tgt;
			hi_w = {{W{1'b0}}, q} * {{W{1'b0}}, span};
			lo_w = {{W{1'b0}}, rem} * {{W{1'b0}}, span};
			if (hi_w[2*W-1:W] != 0 || lo_w[2*W-1:W] != 0) return ST_OVERFLOW;
			lo = lo_w[W-1:0] / tgt;
			sum = {1'b0, hi_w[W-1:0]} + {1'b0, lo};
			if (sum[W]) return ST_OVERFLOW;
			delta = sum[W-1:0] >> 3;
			if (used > tgt) begin
				if (delta == 0) delta = 1;
				if (price + delta < price) return ST_OVERFLOW;
				res = price + delta;
			end else
				res = (delta >= price) ? 1 : price - delta;
			return ST_OK;
		endfunction

		function void note_block(logic [W-1:0] pr [N_RES], logic [W-1:0] us [N_RES]);
			fee_res_t r;
			st_t s;
			s = ST_OK;
			foreach (r.p[i]) r.p[i] = '0;
			for (int i = 0; i < N_RES; i++) begin
				s = lane_price(pr[i], us[i], targets[i], r.p[i]);
				if (s != ST_OK) break;
			end
			if (s != ST_OK) foreach (r.p[i]) r.p[i] = '0;
			r.st = s;
			pending.push_back(r);
		endfunction

		function void check_block(fee_res_t got);
			fee_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item, status %0d", $time, got.st);
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < N_RES; i++)
				if (got.p[i] !== e.p[i]) begin
					$display("%0t: price %0d expected %0d actual %0d", $time, i,
						e.p[i], got.p[i]);
					errors++;
				end
			if (got.st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [W-1:0] cfg_data = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [W-1:0] pc = 0, pm = 0, ps = 0, pb = 0, uc = 0, um = 0, us = 0, ub = 0;
	logic [W-1:0] npc, npm, nps, npb;
	logic [1:0] status;
	fee_board board = new();
	longint cycles = 0;
	bit drain_on = 1;
	int stall_left = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	multi_resource_base_fee_update u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.price_compute(pc), .price_memory(pm), .price_storage(ps),
		.price_bandwidth(pb), .used_compute(uc), .used_memory(um),
		.used_storage(us), .used_bandwidth(ub),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_price_compute(npc), .new_price_memory(npm),
		.new_price_storage(nps), .new_price_bandwidth(npb),
		.status(status)
	);

	always @(posedge clk) begin
		fee_res_t r;
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("testbench failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			r.p[0] = npc; r.p[1] = npm; r.p[2] = nps; r.p[3] = npb;
			r.st = status;
			board.check_block(r);
		end
	end

	// output stall: cycles drawn per item, with runs of no stall
	always @(posedge clk) begin
		int w;
		if (!drain_on) begin
			out_stall  <= 0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			stall_left <= w;
			out_stall  <= (w != 0);
		end else if (out_stall) begin
			stall_left <= stall_left - 1;
			if (stall_left <= 1) out_stall <= 0;
		end
	end

	function automatic logic [W-1:0] rand64();
		logic [W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = v >> $urandom_range(0, 63);
			1: v = $urandom_range(0, 20);
			2: v = ~v >> $urandom_range(50, 63);
			default: v = v >> $urandom_range(30, 63);
		endcase
		return v;
	endfunction

	task automatic write_target(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < N_RES) board.targets[idx] = val;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_block(logic [W-1:0] pr [N_RES], logic [W-1:0] u [N_RES], bit gaps);
		int g;
		g = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14)) : 0;
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		pc <= pr[0]; pm <= pr[1]; ps <= pr[2]; pb <= pr[3];
		uc <= u[0]; um <= u[1]; us <= u[2]; ub <= u[3];
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_block(pr, u);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LANE_LAT + 20) @(posedge clk);
	endtask

	task automatic random_block(bit gaps);
		logic [W-1:0] pr [N_RES], u [N_RES];
		for (int i = 0; i < N_RES; i++) begin
			pr[i] = rand64();
			case ($urandom_range(0, 3))
				0: u[i] = board.targets[i];
				1: u[i] = board.targets[i] + $urandom_range(0, 50);
				2: u[i] = board.targets[i] - $urandom_range(0, 50);
				default: u[i] = rand64();
			endcase
		end
		send_block(pr, u, gaps);
	endtask

	initial begin
		logic [W-1:0] pr [N_RES], u [N_RES];
		logic [W-1:0] mx;
		mx = '1;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		foreach (pr[i]) begin pr[i] = 0; u[i] = 1; end
		send_block(pr, u, 0);
		foreach (pr[i]) begin pr[i] = mx; u[i] = mx; end
		send_block(pr, u, 0);
		foreach (pr[i]) begin pr[i] = 1000; u[i] = 0; end
		send_block(pr, u, 0);
		foreach (pr[i]) begin pr[i] = mx; u[i] = 3; end
		pr[0] = 100;
		send_block(pr, u, 0);
		drain();
		write_target(REG_COMPUTE, 1000);
		write_target(REG_MEMORY, mx);
		write_target(REG_STORAGE, 0);
		write_target(REG_BANDWIDTH, 7);
		write_target(8'd9, 5);
		foreach (pr[i]) begin pr[i] = 800; u[i] = 2000; end
		send_block(pr, u, 0);
		pr[0] = mx; u[0] = 0;
		send_block(pr, u, 0);
		pr[0] = 800; u[0] = 1000; pr[1] = mx; u[1] = 0;
		send_block(pr, u, 0);
		pr[1] = 5; u[1] = mx;
		send_block(pr, u, 0);
		drain();
		write_target(REG_STORAGE, 1);
		foreach (pr[i]) begin pr[i] = mx; u[i] = 0; end
		send_block(pr, u, 0);
		pr[0] = 8000; u[0] = 0; pr[1] = 0; u[1] = 0;
		send_block(pr, u, 0);
		// random phases with varied targets
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			for (int i = 0; i < N_RES; i++)
				write_target(i[CFG_IDX_W-1:0],
					(ph == 6 && i == 1) ? 0 : (ph == 5 ? mx : rand64() | (ph < 5)));
			for (int n = 0; n < 250; n++) begin
				random_block(!(ph == 2 && n < 100));
				if (n == 120) drain();
			end
		end
		drain_on = 0;
		drain();
		if (board.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
